// ----- hw/rtl/lsc_pkg.sv -----
package lsc_pkg;

	localparam int FRAC_BITS = 8;
	localparam int INT_BITS  = 16;
	localparam int IN_BITS   = INT_BITS + FRAC_BITS;
	localparam int CFG_BITS  = 15;
	localparam int DIFF_BITS = IN_BITS + 1;
	localparam int PROD_BITS = 2 * DIFF_BITS;
	localparam int QUO_BITS  = IN_BITS + 2;
	localparam int SUM_BITS  = QUO_BITS + 2;

	typedef logic signed [IN_BITS-1:0]  coord_t;
	typedef logic signed [INT_BITS-1:0] pix_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} seg_t;

	typedef struct packed {
		logic drawn;
		pix_t clip_start_x;
		pix_t clip_start_y;
		pix_t clip_end_x;
		pix_t clip_end_y;
	} res_t;

	// moving point m is clipped along the line toward anchor a
	typedef struct packed {
		logic   drawn;
		logic   act;
		logic   act_next;
		coord_t mx;
		coord_t my;
		coord_t ax;
		coord_t ay;
	} work_t;

endpackage

// ----- hw/rtl/lsc_div.sv -----
module lsc_div #(
	parameter int NUM_W = 50,
	parameter int DEN_W = 25,
	parameter int QUO_W = 26
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	// requires num < den * 2**QUO_W
	logic [DEN_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0] low_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [QUO_W-1:0] low_in;
		logic [QUO_W-1:0] quo_in;
		logic [DEN_W-1:0] den_in;
		logic [DEN_W:0]   t;
		logic             ge;

		if (k == 0) begin : g_first
			always_comb begin
				rem_in = DEN_W'(num[NUM_W-1:QUO_W]);
				low_in = num[QUO_W-1:0];
				quo_in = '0;
				den_in = den;
			end
		end else begin : g_next
			always_comb begin
				rem_in = rem_s[k-1];
				low_in = low_s[k-1];
				quo_in = quo_s[k-1];
				den_in = den_s[k-1];
			end
		end

		always_comb begin
			t  = {rem_in, low_in[QUO_W-1]};
			ge = t >= {1'b0, den_in};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DEN_W'(t - {1'b0, den_in}) : DEN_W'(t);
				low_s[k] <= low_in << 1;
				quo_s[k] <= {quo_in[QUO_W-2:0], ge};
				den_s[k] <= den_in;
			end
		end
	end

	assign quo = quo_s[QUO_W-1];

endmodule

// ----- hw/rtl/lsc_clip.sv -----
module lsc_clip (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  lsc_pkg::work_t       in_item,
	input  lsc_pkg::coord_t      wf,
	input  lsc_pkg::coord_t      hf,
	output logic                 out_valid,
	output lsc_pkg::work_t       out_item
);

	localparam int DB = lsc_pkg::DIFF_BITS;
	localparam int PB = lsc_pkg::PROD_BITS;
	localparam int QB = lsc_pkg::QUO_BITS;
	localparam int SB = lsc_pkg::SUM_BITS;

	typedef struct packed {
		lsc_pkg::work_t  it;
		logic            okx;
		logic            oky;
		logic            negx;
		logic            negy;
		lsc_pkg::coord_t ex;
		lsc_pkg::coord_t ey;
	} side_t;

	function automatic logic [DB-1:0] mag(input logic signed [DB-1:0] v);
		return v[DB-1] ? DB'(-v) : DB'(v);
	endfunction

	// edge setup and deltas
	logic signed [DB-1:0] dx, dy, nx, ny;
	logic                 xedge, yedge;
	lsc_pkg::coord_t      ex, ey;

	always_comb begin
		xedge = in_item.mx < 0 || in_item.mx > wf;
		yedge = in_item.my < 0 || in_item.my > hf;
		ex    = in_item.mx < 0 ? '0 : wf;
		ey    = in_item.my < 0 ? '0 : hf;
		dx    = DB'(in_item.mx) - DB'(in_item.ax);
		dy    = DB'(in_item.my) - DB'(in_item.ay);
		nx    = DB'(ex) - DB'(in_item.ax);
		ny    = DB'(ey) - DB'(in_item.ay);
	end

	logic          v_s1;
	side_t         sd_s1;
	logic [DB-1:0] adx_s1, ady_s1, anx_s1, any_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1.it   <= in_item;
			sd_s1.okx  <= in_item.act && xedge && dx != '0;
			sd_s1.oky  <= in_item.act && yedge && dy != '0;
			sd_s1.negx <= dy[DB-1] ^ nx[DB-1] ^ dx[DB-1];
			sd_s1.negy <= dx[DB-1] ^ ny[DB-1] ^ dy[DB-1];
			sd_s1.ex   <= ex;
			sd_s1.ey   <= ey;
			adx_s1     <= mag(dx);
			ady_s1     <= mag(dy);
			anx_s1     <= mag(nx);
			any_s1     <= mag(ny);
		end
	end

	// products
	logic          v_s2;
	side_t         sd_s2;
	logic [PB-1:0] px_s2, py_s2;
	logic [DB-1:0] adx_s2, ady_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s2  <= sd_s1;
			px_s2  <= ady_s1 * anx_s1;
			py_s2  <= adx_s1 * any_s1;
			adx_s2 <= adx_s1;
			ady_s2 <= ady_s1;
		end
	end

	// quotient range check: too large means the crossing is far off screen
	logic          v_s3;
	side_t         sd_chk;
	side_t         sd_s3;
	logic [PB-1:0] px_s3, py_s3;
	logic [DB-1:0] adx_s3, ady_s3;

	always_comb begin
		sd_chk     = sd_s2;
		sd_chk.okx = sd_s2.okx && ({1'b0, px_s2} < {adx_s2, QB'(0)});
		sd_chk.oky = sd_s2.oky && ({1'b0, py_s2} < {ady_s2, QB'(0)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s3  <= sd_chk;
			px_s3  <= px_s2;
			py_s3  <= py_s2;
			adx_s3 <= adx_s2;
			ady_s3 <= ady_s2;
		end
	end

	logic [QB-1:0] qx, qy;

	lsc_div #(.NUM_W(PB), .DEN_W(DB), .QUO_W(QB)) u_div_x (
		.clk (clk),
		.en  (en),
		.num (px_s3),
		.den (adx_s3),
		.quo (qx)
	);

	lsc_div #(.NUM_W(PB), .DEN_W(DB), .QUO_W(QB)) u_div_y (
		.clk (clk),
		.en  (en),
		.num (py_s3),
		.den (ady_s3),
		.quo (qy)
	);

	// side data follows the divider stages
	logic  v_sd [QB];
	side_t sd_sd [QB];

	for (genvar k = 0; k < QB; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k] <= 1'b0;
			end else if (en) begin
				v_sd[k] <= (k == 0) ? v_s3 : v_sd[k == 0 ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd_sd[k] <= (k == 0) ? sd_s3 : sd_sd[k == 0 ? 0 : k-1];
			end
		end
	end

	// crossing points and selection
	side_t                sd;
	logic signed [SB-1:0] iy, ix;
	logic                 xok, yok;
	lsc_pkg::work_t       nxt;

	always_comb begin
		sd  = sd_sd[QB-1];
		iy  = SB'(sd.it.ay) + (sd.negx ? -SB'(qx) : SB'(qx));
		ix  = SB'(sd.it.ax) + (sd.negy ? -SB'(qy) : SB'(qy));
		xok = sd.okx && iy >= 0 && iy <= SB'(hf);
		yok = sd.oky && ix >= 0 && ix <= SB'(wf);
		nxt = sd.it;
		if (yok) begin
			nxt.mx = lsc_pkg::IN_BITS'(ix);
			nxt.my = sd.ey;
		end else if (xok) begin
			nxt.mx = sd.ex;
			nxt.my = lsc_pkg::IN_BITS'(iy);
		end
	end

	logic           v_s4;
	lsc_pkg::work_t it_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_sd[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s4 <= nxt;
		end
	end

	assign out_valid = v_s4;
	assign out_item  = it_s4;

endmodule

// ----- hw/rtl/line_segment_screen_clipper.sv -----
// Clips one line segment per clock against the screen rectangle from 0 to
// screen_width by 0 to screen_height (pixels, endpoints in signed fixed point with
// 8 fraction bits) and returns a drawn flag plus integer endpoints truncated
// toward zero; a rejected segment returns all-zero endpoints. Throughput is one
// segment per cycle; the two clip passes run in series
// (second endpoint, then first), each built around a pair of 26-stage restoring
// divider pipelines. A stall on the result channel holds the whole pipeline.
// Configuration writes are always ready and must only be made while idle.
module line_segment_screen_clipper (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              seg_valid,
	output logic              seg_stall,
	input  lsc_pkg::seg_t     seg,
	output logic              clip_valid,
	input  logic              clip_stall,
	output lsc_pkg::res_t     clip,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  lsc_pkg::reg_idx_t cfg_index,
	input  logic [lsc_pkg::CFG_BITS-1:0] cfg_data
);

	localparam int FB = lsc_pkg::FRAC_BITS;
	localparam int IB = lsc_pkg::IN_BITS;
	localparam lsc_pkg::coord_t BIAS = IB'((1 << FB) - 1);

	function automatic lsc_pkg::pix_t to_pix(input lsc_pkg::coord_t v);
		lsc_pkg::coord_t t;
		t = v + (v < 0 ? BIAS : '0);
		return lsc_pkg::INT_BITS'(t >>> FB);
	endfunction

	logic [lsc_pkg::CFG_BITS-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lsc_pkg::CFG_BITS'(640);
			height_q <= lsc_pkg::CFG_BITS'(480);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lsc_pkg::REG_WIDTH:  width_q  <= cfg_data;
				lsc_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	lsc_pkg::coord_t wf, hf;
	logic            en;

	assign wf        = IB'({width_q, FB'(0)});
	assign hf        = IB'({height_q, FB'(0)});
	assign en        = !(clip_valid && clip_stall);
	assign seg_stall = !en;

	// trivial accept / reject
	logic           in1, in2, rej;
	lsc_pkg::work_t cls;

	always_comb begin
		in1 = seg.start_x >= 0 && seg.start_x <= wf && seg.start_y >= 0 && seg.start_y <= hf;
		in2 = seg.end_x >= 0 && seg.end_x <= wf && seg.end_y >= 0 && seg.end_y <= hf;
		rej = !in1 && !in2 &&
			((seg.start_x < 0 && seg.end_x < 0) || (seg.start_x > wf && seg.end_x > wf) ||
			 (seg.start_y < 0 && seg.end_y < 0) || (seg.start_y > hf && seg.end_y > hf));
		cls.drawn    = !rej;
		cls.act      = !rej && !in2;
		cls.act_next = !rej && !in1;
		cls.mx       = seg.end_x;
		cls.my       = seg.end_y;
		cls.ax       = seg.start_x;
		cls.ay       = seg.start_y;
	end

	logic           v_s1;
	lsc_pkg::work_t it_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= seg_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= cls;
		end
	end

	logic           va, vb;
	lsc_pkg::work_t ia, ib, sw;

	lsc_clip u_clip_end (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.in_item   (it_s1),
		.wf        (wf),
		.hf        (hf),
		.out_valid (va),
		.out_item  (ia)
	);

	// first endpoint now moves, anchored at the clipped second endpoint
	always_comb begin
		sw.drawn    = ia.drawn;
		sw.act      = ia.act_next;
		sw.act_next = 1'b0;
		sw.mx       = ia.ax;
		sw.my       = ia.ay;
		sw.ax       = ia.mx;
		sw.ay       = ia.my;
	end

	lsc_clip u_clip_start (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (va),
		.in_item   (sw),
		.wf        (wf),
		.hf        (hf),
		.out_valid (vb),
		.out_item  (ib)
	);

	logic          res_valid_q;
	lsc_pkg::res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= vb;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.drawn        <= ib.drawn;
			res_q.clip_start_x <= ib.drawn ? to_pix(ib.mx) : '0;
			res_q.clip_start_y <= ib.drawn ? to_pix(ib.my) : '0;
			res_q.clip_end_x   <= ib.drawn ? to_pix(ib.ax) : '0;
			res_q.clip_end_y   <= ib.drawn ? to_pix(ib.ay) : '0;
		end
	end

	assign clip_valid = res_valid_q;
	assign clip       = res_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		clip_valid && !clip.drawn |-> clip.clip_start_x == '0 && clip.clip_start_y == '0 &&
			clip.clip_end_x == '0 && clip.clip_end_y == '0)
		else $error("rejected segment with nonzero endpoints");

	assert property (@(posedge clk) disable iff (!arst_n)
		seg_stall |-> clip_valid)
		else $error("input stalled with no result waiting");

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_index == lsc_pkg::REG_WIDTH |=> width_q == $past(cfg_data))
		else $error("width register write lost");

endmodule

// ----- dv/line_segment_screen_clipper_tb.sv -----
module line_segment_screen_clipper_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 80;
	localparam int ITEMS_PER_PHASE = 155;

	typedef struct {
		lsc_pkg::seg_t s;
		bit            typed;
		lsc_pkg::res_t r;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic seg_valid = 1'b0;
	logic seg_stall;
	lsc_pkg::seg_t seg = '0;
	logic clip_valid;
	logic clip_stall = 1'b0;
	lsc_pkg::res_t clip;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	lsc_pkg::reg_idx_t cfg_index = lsc_pkg::REG_WIDTH;
	logic [lsc_pkg::CFG_BITS-1:0] cfg_data = '0;

	lsc_pkg::res_t pending_clips[$];
	int errors = 0;
	int segs_sent = 0;
	int clips_seen = 0;
	int rejects_seen = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	longint scr_w = 640;
	longint scr_h = 480;

	line_segment_screen_clipper DUT (
		.clk(clk), .arst_n(arst_n),
		.seg_valid(seg_valid), .seg_stall(seg_stall), .seg(seg),
		.clip_valid(clip_valid), .clip_stall(clip_stall), .clip(clip),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint trunc_div(longint num, longint den);
		return num / den;
	endfunction

	// move (mx,my) toward the screen along the line from anchor (ax,ay)
	function automatic void move_to_edge(inout longint mx, inout longint my,
			input longint ax, input longint ay, input longint wf, input longint hf);
		longint dx, dy, ex, ey, iy, ix;
		bit xok, yok;
		dx = mx - ax;
		dy = my - ay;
		xok = 0;
		yok = 0;
		iy = 0;
		ix = 0;
		ex = (mx < 0) ? 0 : wf;
		ey = (my < 0) ? 0 : hf;
		if (((mx < 0) || (mx > wf)) && dx != 0) begin
			iy = ay + trunc_div(dy * (ex - ax), dx);
			xok = iy >= 0 && iy <= hf;
		end
		if (((my < 0) || (my > hf)) && dy != 0) begin
			ix = ax + trunc_div(dx * (ey - ay), dy);
			yok = ix >= 0 && ix <= wf;
		end
		if (xok) begin
			mx = ex;
			my = iy;
		end
		if (yok) begin
			mx = ix;
			my = ey;
		end
	endfunction

	function automatic lsc_pkg::pix_t to_pixel(longint v);
		longint r;
		r = (v >= 0) ? (v >>> lsc_pkg::FRAC_BITS) : -((-v) >>> lsc_pkg::FRAC_BITS);
		return lsc_pkg::pix_t'(r);
	endfunction

	function automatic lsc_pkg::res_t clip_segment(lsc_pkg::seg_t s);
		longint x1, y1, x2, y2, wf, hf;
		bit in1, in2;
		lsc_pkg::res_t r;
		x1 = longint'(s.start_x);
		y1 = longint'(s.start_y);
		x2 = longint'(s.end_x);
		y2 = longint'(s.end_y);
		wf = scr_w << lsc_pkg::FRAC_BITS;
		hf = scr_h << lsc_pkg::FRAC_BITS;
		in1 = x1 >= 0 && x1 <= wf && y1 >= 0 && y1 <= hf;
		in2 = x2 >= 0 && x2 <= wf && y2 >= 0 && y2 <= hf;
		r = '0;
		if (!in1 && !in2 && ((x1 < 0 && x2 < 0) || (x1 > wf && x2 > wf) ||
				(y1 < 0 && y2 < 0) || (y1 > hf && y2 > hf)))
			return r;
		if (!in2)
			move_to_edge(x2, y2, x1, y1, wf, hf);
		if (!in1)
			move_to_edge(x1, y1, x2, y2, wf, hf);
		r.drawn = 1'b1;
		r.clip_start_x = to_pixel(x1);
		r.clip_start_y = to_pixel(y1);
		r.clip_end_x = to_pixel(x2);
		r.clip_end_y = to_pixel(y2);
		return r;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		errors++;
		$display("mismatch on %s: got %0d expected %0d at %0t", field, got, want, $realtime);
	endtask

	always @(posedge clk) begin
		clip_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		lsc_pkg::res_t want;
		if (arst_n && clip_valid && !clip_stall) begin
			clips_seen++;
			if (!clip.drawn)
				rejects_seen++;
			if (pending_clips.size() == 0) begin
				report_mismatch("unexpected transaction", 1, 0);
			end else begin
				want = pending_clips.pop_front();
				if (clip.drawn !== want.drawn)
					report_mismatch("drawn", clip.drawn, want.drawn);
				if (clip.clip_start_x !== want.clip_start_x)
					report_mismatch("clip_start_x", clip.clip_start_x, want.clip_start_x);
				if (clip.clip_start_y !== want.clip_start_y)
					report_mismatch("clip_start_y", clip.clip_start_y, want.clip_start_y);
				if (clip.clip_end_x !== want.clip_end_x)
					report_mismatch("clip_end_x", clip.clip_end_x, want.clip_end_x);
				if (clip.clip_end_y !== want.clip_end_y)
					report_mismatch("clip_end_y", clip.clip_end_y, want.clip_end_y);
			end
		end
	end

	always @(posedge clk) begin
		if ((seg_valid && !seg_stall) || (clip_valid && !clip_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d transactions outstanding", pending_clips.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_segment(lsc_pkg::seg_t s, bit typed, lsc_pkg::res_t typed_res);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			seg_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct)
				@(posedge clk);
		end
		seg_valid <= 1'b1;
		seg <= s;
		@(posedge clk);
		while (seg_stall)
			@(posedge clk);
		pending_clips.push_back(typed ? typed_res : clip_segment(s));
		segs_sent++;
	endtask

	task automatic drain_pipe();
		seg_valid <= 1'b0;
		@(posedge clk);
		while (pending_clips.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(lsc_pkg::reg_idx_t idx, logic [lsc_pkg::CFG_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == lsc_pkg::REG_WIDTH)
			scr_w = val;
		else
			scr_h = val;
	endtask

	function automatic lsc_pkg::coord_t pick_coord(longint lim);
		longint v, span;
		span = lim << lsc_pkg::FRAC_BITS;
		case ($urandom_range(0, 9))
			0, 1: v = longint'(lsc_pkg::coord_t'($urandom));
			2: v = $urandom_range(0, 1) ? span : 0;
			3: v = longint'($urandom_range(0, 1023)) - 512 + ($urandom_range(0, 1) ? span : 0);
			default: v = longint'($urandom_range(0, 3 * span)) - span;
		endcase
		if (v > 8388607)
			v = 8388607;
		if (v < -8388608)
			v = -8388608;
		return lsc_pkg::coord_t'(v);
	endfunction

	task automatic random_segments(int n);
		lsc_pkg::seg_t s;
		for (int i = 0; i < n; i++) begin
			s.start_x = pick_coord(scr_w);
			s.start_y = pick_coord(scr_h);
			s.end_x = pick_coord(scr_w);
			s.end_y = pick_coord(scr_h);
			// axis-aligned segments exercise the zero-delta edge skip
			case ($urandom_range(0, 9))
				0: s.end_x = s.start_x;
				1: s.end_y = s.start_y;
				default: ;
			endcase
			send_segment(s, 1'b0, '0);
		end
	endtask

	stim_row_t directed[$];

	task automatic add_row(int sx, int sy, int ex, int ey, bit typed, lsc_pkg::res_t r);
		stim_row_t row;
		row.s = '{lsc_pkg::coord_t'(sx), lsc_pkg::coord_t'(sy),
			lsc_pkg::coord_t'(ex), lsc_pkg::coord_t'(ey)};
		row.typed = typed;
		row.r = r;
		directed.push_back(row);
	endtask

	initial begin
		longint widths[5];
		longint heights[5];
		widths = '{640, 1, 32767, 0, 1};
		heights = '{480, 1, 32767, 0, 32767};
		widths[3] = $urandom_range(2, 2000);
		heights[3] = $urandom_range(2, 2000);

		add_row(2560, 5120, 7808, 10432, 1, '{1'b1, 16'sd10, 16'sd20, 16'sd30, 16'sd40});
		add_row(0, 0, 163840, 122880, 1, '{1'b1, 16'sd0, 16'sd0, 16'sd640, 16'sd480});
		add_row(-256, 100, -512, 200, 1, '0);
		add_row(-8388608, -8388608, -8388608, -8388608, 1, '0);
		add_row(8388607, 8388607, 8388607, 8388607, 1, '0);
		add_row(100, 130000, 5000, 200000, 1, '0);
		add_row(100, -1, 5000, -300, 1, '0);
		add_row(-2560, 5120, 2560, 5120, 0, '0);
		add_row(2560, -5000, 2560, 200000, 0, '0);
		add_row(-25600, -25600, 200000, 150000, 0, '0);
		add_row(-2560, 130000, 170000, -2560, 0, '0);
		add_row(-8388608, -8388608, 8388607, 8388607, 0, '0);
		add_row(-8388608, 8388607, 8388607, -8388608, 0, '0);
		add_row(5000, 5000, 300000, 7000, 0, '0);
		add_row(300000, 7000, 5000, 5000, 0, '0);
		add_row(-1000, 60000, 80000, -3000, 0, '0);
		add_row(-300, 200, 200, 124000, 0, '0);
		add_row(164000, 123000, -10, -10, 0, '0);
		add_row(-5000, -5000, -5000, 500, 0, '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_segment(directed[i].s, directed[i].typed, directed[i].r);
		// hold off until the pipeline is empty
		drain_pipe();

		foreach (widths[k]) begin
			if (k > 0) begin
				drain_pipe();
				write_reg(lsc_pkg::REG_WIDTH, widths[k][lsc_pkg::CFG_BITS-1:0]);
				write_reg(lsc_pkg::REG_HEIGHT, heights[k][lsc_pkg::CFG_BITS-1:0]);
				cfg_valid <= 1'b0;
				@(posedge clk);
			end
			for (int ph = 0; ph < 3; ph++) begin
				send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 45 : 0;
				recv_stall_pct = (ph == 0) ? 45 : (ph == 1) ? 10 : 0;
				random_segments(ITEMS_PER_PHASE / 2 + $urandom_range(0, ITEMS_PER_PHASE / 4));
			end
		end

		drain_pipe();
		$display("sent %0d segments over %0d screen sizes with idle and stall mixes",
			segs_sent, 5);
		$display("checked %0d clipped results, %0d of them rejected", clips_seen, rejects_seen);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
